// File: hw/rtl/kscm_pkg.sv
// kscm_pkg: widths, defaults, register map and cell handshake types for
// the k-way sorted count merge. No dependencies.
package kscm_pkg;

  localparam int LANES_DEF    = 8;
  localparam int KEY_BITS_DEF = 64;

  // fixed field widths on the channels
  localparam int LANE_W  = 3;
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 4;

  // APB register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[APB_AW-1]
  localparam logic REG_LANES_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] LANES_IN_USE_RST = CFG_W'(8);

  // per-cell control from the sequencer
  typedef struct packed {
    logic wr;     // input word addressed to this lane
    logic eol;    // word marks the lane ended
    logic clr;    // result of this lane is being emitted
  } kscm_cell_ctl_t;

  // per-cell status back to the sequencer
  typedef struct packed {
    logic               waiting;
    logic               ended;
    logic               hit;
    logic [COUNT_W-1:0] count;
  } kscm_cell_sts_t;

endpackage

// File: hw/rtl/kscm_if.sv
// kscm_if: valid/ready channel interfaces for input records and merged
// results. Depends on kscm_pkg.
interface kscm_in_if import kscm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LANE_W-1:0]  lane;
  logic [KEY_W-1:0]   record_key;
  logic [COUNT_W-1:0] record_count;
  logic               end_of_lane;

  modport source (output valid, lane, record_key, record_count, end_of_lane, input ready);
  modport sink   (input valid, lane, record_key, record_count, end_of_lane, output ready);
endinterface

interface kscm_out_if import kscm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LANE_W-1:0]  out_lane;
  logic [KEY_W-1:0]   merged_key;
  logic [COUNT_W-1:0] lane_count;
  logic               row_last;

  modport source (output valid, out_lane, merged_key, lane_count, row_last, input ready);
  modport sink   (input valid, out_lane, merged_key, lane_count, row_last, output ready);
endinterface

// File: hw/rtl/kscm_cell.sv
// kscm_cell: one lane of the merge chain. Holds the lane's head record and
// flags, and folds its key into the running minimum passed to the next cell.
// Depends on kscm_pkg.
module kscm_cell import kscm_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                act_i,
  input  kscm_cell_ctl_t      ctl_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [COUNT_W-1:0]  count_i,
  input  logic [KEY_BITS-1:0] best_i,
  input  logic                min_vld_i,
  input  logic [KEY_BITS-1:0] min_key_i,
  output logic                min_vld_o,
  output logic [KEY_BITS-1:0] min_key_o,
  output kscm_cell_sts_t      sts_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic                wait_q, wait_d;
  logic                end_q, end_d;
  logic                mvld_q, mvld_d;
  logic [KEY_BITS-1:0] mkey_q, mkey_d;
  logic                holds;
  logic                hit;

  assign holds = act_i & ~end_q & ~wait_q;
  assign hit   = holds & (key_q == best_i);

  always_comb begin
    key_d  = key_q;
    cnt_d  = cnt_q;
    wait_d = wait_q;
    end_d  = end_q;
    if (ctl_i.wr && act_i && wait_q && !end_q) begin
      if (ctl_i.eol) begin
        end_d = 1'b1;
      end else begin
        key_d = key_i;
        cnt_d = count_i;
      end
      wait_d = 1'b0;
    end else if (ctl_i.clr && hit) begin
      wait_d = 1'b1;
    end
  end

  // running minimum, one cell further each cycle
  always_comb begin
    if (holds && (!min_vld_i || key_q < min_key_i)) begin
      mvld_d = 1'b1;
      mkey_d = key_q;
    end else begin
      mvld_d = min_vld_i;
      mkey_d = min_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= 1'b1;
      end_q  <= 1'b0;
      mvld_q <= 1'b0;
    end else begin
      wait_q <= wait_d;
      end_q  <= end_d;
      mvld_q <= mvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    cnt_q  <= cnt_d;
    mkey_q <= mkey_d;
  end

  assign min_vld_o     = mvld_q;
  assign min_key_o     = mkey_q;
  assign sts_o.waiting = wait_q;
  assign sts_o.ended   = end_q;
  assign sts_o.hit     = hit;
  assign sts_o.count   = cnt_q;

endmodule

// File: hw/rtl/kway_sorted_count_merge.sv
// kway_sorted_count_merge: k-way merge of key-sorted (key, count) streams.
// One input word at a time: the word is accepted, then the row is checked. An input
// that completes a row starts a scan through the cell chain, then one result per
// cycle for each lane in use while the output is not stalled. Output stalls hold
// the row in place.
// Reset: all lanes waiting, none ended, lanes_in_use = 8; heads are undefined.
module kway_sorted_count_merge import kscm_pkg::*; #(
  parameter int LANES    = LANES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kscm_in_if.sink           rec_i,
  kscm_out_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W  = $clog2(LANES);
  localparam int NCNT_W = $clog2(LANES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CFG_W-1:0]    lanes_in_use_q;
  logic [NCNT_W-1:0]   n_eff;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [KEY_BITS-1:0] best_q;
  logic                out_vld_q, out_vld_d;
  logic [LANE_W-1:0]   out_lane_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [COUNT_W-1:0]  out_cnt_q;
  logic                out_last_q;

  logic                rec_acc;
  logic                emit_go;
  logic                idx_last;
  logic                row_ok;
  logic [LANES-1:0]    act;
  logic [LANES-1:0]    waiting;
  logic [LANES-1:0]    ended;
  kscm_cell_ctl_t      ctl   [LANES];
  kscm_cell_sts_t      sts   [LANES];
  logic                mvld  [LANES+1];
  logic [KEY_BITS-1:0] mkey  [LANES+1];
  kscm_cell_sts_t      sel;

  // ---- register port ----
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == REG_LANES_IN_USE) ? APB_DW'(lanes_in_use_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_in_use_q <= LANES_IN_USE_RST;
    end else if (psel && penable && pwrite && (paddr[APB_AW-1] == REG_LANES_IN_USE)) begin
      lanes_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (lanes_in_use_q == '0) begin
      n_eff = NCNT_W'(1);
    end else if (32'(lanes_in_use_q) > LANES) begin
      n_eff = NCNT_W'(LANES);
    end else begin
      n_eff = NCNT_W'(lanes_in_use_q);
    end
  end

  // ---- cell chain ----
  assign rec_acc = rec_i.valid & rec_i.ready;
  assign mvld[0] = 1'b0;
  assign mkey[0] = '0;

  for (genvar g = 0; g < LANES; g++) begin : g_cell
    assign act[g]     = n_eff > NCNT_W'(g);
    assign ctl[g].wr  = rec_acc && (32'(rec_i.lane) == g);
    assign ctl[g].eol = rec_i.end_of_lane;
    assign ctl[g].clr = emit_go && (32'(idx_q) == g);
    assign waiting[g] = sts[g].waiting;
    assign ended[g]   = sts[g].ended;

    kscm_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .act_i    (act[g]),
      .ctl_i    (ctl[g]),
      .key_i    (rec_i.record_key[KEY_BITS-1:0]),
      .count_i  (rec_i.record_count),
      .best_i   (best_q),
      .min_vld_i(mvld[g]),
      .min_key_i(mkey[g]),
      .min_vld_o(mvld[g+1]),
      .min_key_o(mkey[g+1]),
      .sts_o    (sts[g])
    );
  end

  // a row is due when every lane in use holds a head or has ended, and one holds
  assign row_ok = (&(~act | ended | ~waiting)) & (|(act & ~ended));

  // ---- sequencer ----
  assign rec_i.ready = (state_q == ST_IDLE);
  assign emit_go     = (state_q == ST_EMIT) && (!out_vld_q || res_o.ready);
  assign idx_last    = (32'(idx_q) + 32'd1) == 32'(n_eff);
  assign sel         = sts[idx_q];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (rec_acc) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_d   = '0;
        idx_d   = '0;
        state_d = row_ok ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        // last cell's minimum is settled once the chain has been filled
        if (cnt_q == IDX_W'(LANES - 1)) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (idx_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit_go) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && cnt_q == IDX_W'(LANES - 1)) begin
      best_q <= mkey[LANES];
    end
    if (emit_go) begin
      out_lane_q <= LANE_W'(idx_q);
      out_key_q  <= KEY_W'(best_q);
      out_cnt_q  <= sel.hit ? sel.count : '0;
      out_last_q <= idx_last;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.out_lane   = out_lane_q;
  assign res_o.merged_key = out_key_q;
  assign res_o.lane_count = out_cnt_q;
  assign res_o.row_last   = out_last_q;

endmodule

// File: tb/kscm_merge_checker.sv
// kscm_merge_checker: watches the record and result channels and the APB port,
// predicts every merged row word and compares it with what the block emits.
// Depends on kscm_pkg and the channel interfaces in kscm_if.
module kscm_merge_checker import kscm_pkg::*; #(
  parameter int LANES    = LANES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kscm_in_if                rec_mon,
  kscm_out_if               res_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                pending_o,
  output logic [LANES-1:0]  lane_open_o,
  output logic [LANES-1:0]  lane_ended_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

  typedef struct packed {
    logic [LANE_W-1:0]  lane;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic               last;
  } row_word_t;

  row_word_t          row_words_q[$];
  logic [KEY_W-1:0]   head_key_q[LANES];
  logic [COUNT_W-1:0] head_cnt_q[LANES];
  logic [LANES-1:0]   waiting_q;
  logic [LANES-1:0]   ended_q;
  logic [CFG_W-1:0]   lanes_cfg_q;
  int                 fails;

  assign fail_count_o = fails;
  assign lane_open_o  = waiting_q & ~ended_q;
  assign lane_ended_o = ended_q;

  function automatic int unsigned lanes_eff(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > LANES) return LANES;
    return 32'(v);
  endfunction

  // apply one record word to the lane heads, then emit a row if every
  // live lane holds a head
  task automatic merge_record(logic [LANE_W-1:0] lane, logic [KEY_W-1:0] key,
                              logic [COUNT_W-1:0] cnt, logic eol);
    int unsigned n;
    int unsigned l;
    int          i;
    bit          any_head;
    bit          hit;
    logic [KEY_W-1:0] best;
    row_word_t   w;
    n = lanes_eff(lanes_cfg_q);
    l = lane;
    if (l < n && waiting_q[l] && !ended_q[l]) begin
      if (eol) begin
        ended_q[l] = 1'b1;
      end else begin
        head_key_q[l] = key & KEY_MASK;
        head_cnt_q[l] = cnt;
      end
      waiting_q[l] = 1'b0;
    end
    any_head = 1'b0;
    best     = '0;
    for (i = 0; i < int'(n); i++) begin
      if (ended_q[i]) continue;
      if (waiting_q[i]) return;
      if (!any_head || head_key_q[i] < best) best = head_key_q[i];
      any_head = 1'b1;
    end
    if (!any_head) return;
    for (i = 0; i < int'(n); i++) begin
      hit     = !ended_q[i] && !waiting_q[i] && head_key_q[i] == best;
      w.lane  = LANE_W'(i);
      w.key   = best;
      w.count = hit ? head_cnt_q[i] : '0;
      w.last  = (i + 1 == int'(n));
      row_words_q.push_back(w);
      if (hit) waiting_q[i] = 1'b1;
    end
  endtask

  task automatic check_result();
    row_word_t w;
    if (row_words_q.size() == 0) begin
      fails++;
      $error("unexpected result word: out_lane %0d merged_key %h lane_count %0d",
             res_mon.out_lane, res_mon.merged_key, res_mon.lane_count);
      return;
    end
    w = row_words_q.pop_front();
    if (res_mon.out_lane !== w.lane) begin
      fails++;
      $error("out_lane: expected %0d, actual %0d", w.lane, res_mon.out_lane);
    end
    if (res_mon.merged_key !== w.key) begin
      fails++;
      $error("merged_key: expected %h, actual %h", w.key, res_mon.merged_key);
    end
    if (res_mon.lane_count !== w.count) begin
      fails++;
      $error("lane_count: expected %0d, actual %0d", w.count, res_mon.lane_count);
    end
    if (res_mon.row_last !== w.last) begin
      fails++;
      $error("row_last: expected %0d, actual %0d", w.last, res_mon.row_last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_words_q.delete();
      waiting_q   = '1;
      ended_q     = '0;
      lanes_cfg_q = LANES_IN_USE_RST;
      fails       = 0;
      for (int i = 0; i < LANES; i++) begin
        head_key_q[i] = '0;
        head_cnt_q[i] = '0;
      end
    end else begin
      // results always trail the record that produced them, so check first
      if (res_mon.valid && res_mon.ready) check_result();
      if (rec_mon.valid && rec_mon.ready)
        merge_record(rec_mon.lane, rec_mon.record_key, rec_mon.record_count,
                     rec_mon.end_of_lane);
      if (psel && penable && pwrite && pready && paddr[APB_AW-1] == REG_LANES_IN_USE)
        lanes_cfg_q = pwdata[CFG_W-1:0];
    end
    pending_o = row_words_q.size();
  end

endmodule

// File: tb/tb_top.sv
// tb_top: stimulus and verdict for kway_sorted_count_merge. Drives sorted
// record streams, noise and APB writes; checking lives in kscm_merge_checker.
// Depends on kscm_pkg, kscm_if and the checker.
module tb_top;
  import kscm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES      = LANES_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_LEN   = 400;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int               fail_count;
  int               pending;
  logic [LANES-1:0] lane_open;
  logic [LANES-1:0] lane_ended;

  int               send_idle;
  int               recv_idle;
  bit               hold_req;
  int               lanes_eff;
  logic [KEY_W-1:0] next_key[LANES];
  int               idle_cycles;
  int               in_words;
  int               out_words;

  kscm_in_if  rec_if ();
  kscm_out_if res_if ();

  kway_sorted_count_merge #(
    .LANES    (LANES),
    .KEY_BITS (KEY_BITS_DEF)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (rec_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kscm_merge_checker #(
    .LANES    (LANES),
    .KEY_BITS (KEY_BITS_DEF)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_mon      (rec_if),
    .res_mon      (res_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .lane_open_o  (lane_open),
    .lane_ended_o (lane_ended)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random backpressure, plus one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk_i);
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rec_if.valid && rec_if.ready) in_words++;
      if (res_if.valid && res_if.ready) out_words++;
      if ((rec_if.valid && rec_if.ready) || (res_if.valid && res_if.ready) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_LANES_IN_USE, 2'b00};
    pwdata  <= APB_DW'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (v == '0) lanes_eff = 1;
    else if (int'(v) > LANES) lanes_eff = LANES;
    else lanes_eff = int'(v);
  endtask

  task automatic push_word(logic [LANE_W-1:0] lane, logic [KEY_W-1:0] key,
                           logic [COUNT_W-1:0] cnt, logic eol);
    // the previous word drops valid on its own falling edge
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      rec_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rec_if.valid        <= 1'b1;
    rec_if.lane         <= lane;
    rec_if.record_key   <= key;
    rec_if.record_count <= cnt;
    rec_if.end_of_lane  <= eol;
    do @(posedge clk_i); while (!rec_if.ready);
    @(negedge clk_i);
    rec_if.valid <= 1'b0;
  endtask

  // wait out every pending result word, then the scan time of the block
  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (LANES + 16) @(negedge clk_i);
  endtask

  task automatic noise_word(logic eol);
    push_word(LANE_W'($urandom_range(7)), {$urandom, $urandom}, $urandom, eol);
  endtask

  // refill one waiting lane with the next key of its sorted stream
  task automatic stream_word(int eol_pct, output bit useful);
    int               cand[$];
    int               l;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < lanes_eff; i++)
      if (lane_open[i]) cand.push_back(i);
    if (cand.size() == 0) begin
      // no lane can take a word: an ignored word triggers the row check
      noise_word(1'b0);
      useful = 1'b0;
      return;
    end
    l           = cand[$urandom_range(cand.size() - 1)];
    key         = next_key[l] + $urandom_range(2);
    next_key[l] = key;
    push_word(LANE_W'(l), key, $urandom, $urandom_range(99) < eol_pct);
    useful = 1'b1;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] cfg, int n_words, int eol_pct, bit squeeze);
    logic [KEY_W-1:0] base;
    int               sent;
    bit               useful;
    cfg_write(cfg);
    base = {$urandom, $urandom};
    for (int i = 0; i < LANES; i++) next_key[i] = base + $urandom_range(3);
    sent = 0;
    while (sent < n_words) begin
      if (squeeze && sent == 15) hold_req = 1'b1;
      if ($urandom_range(99) < 15) begin
        noise_word(1'b0);
      end else begin
        stream_word(eol_pct, useful);
        if (useful) sent++;
      end
    end
    settle();
  endtask

  initial begin
    bit useful;
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    rec_if.valid        = 1'b0;
    rec_if.lane         = '0;
    rec_if.record_key   = '0;
    rec_if.record_count = '0;
    rec_if.end_of_lane  = 1'b0;
    hold_req            = 1'b0;
    send_idle           = 26;
    recv_idle           = 71;
    lanes_eff           = LANES;
    idle_cycles         = 0;
    in_words            = 0;
    out_words           = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extreme keys and counts across all eight lanes
    push_word(3'd0, 64'h0, 32'hFFFF_FFFF, 1'b0);
    push_word(3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
    push_word(3'd2, 64'h10, 32'd1, 1'b0);
    push_word(3'd3, 64'h10, 32'd2, 1'b0);
    push_word(3'd4, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0);
    push_word(3'd5, 64'h10, 32'd3, 1'b0);
    push_word(3'd6, 64'h7FFF_FFFF_FFFF_FFFF, 32'd4, 1'b0);
    push_word(3'd7, 64'h10, 32'd5, 1'b0);
    // lane 3 holds a head: ignored
    push_word(3'd3, 64'h0, 32'd9, 1'b0);
    push_word(3'd0, 64'h10, 32'd6, 1'b0);
    push_word(3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd7, 1'b0);
    push_word(3'd2, 64'hFFFF_FFFF_FFFF_FFFF, 32'd8, 1'b0);
    push_word(3'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'd9, 1'b0);
    push_word(3'd5, 64'hFFFF_FFFF_FFFF_FFFF, 32'd10, 1'b0);
    push_word(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 32'd11, 1'b0);
    push_word(3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // all heads equal: every lane hits
    push_word(3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5555_5555, 1'b0);
    settle();
    // zero acts as a single lane; lane 3 is then out of use
    cfg_write(4'd0);
    push_word(3'd3, 64'h1234, 32'd1, 1'b0);
    push_word(3'd0, 64'h1234, 32'hAAAA_AAAA, 1'b0);
    settle();
    // above the lane count clamps to all lanes; lane 7 gets the smallest key
    cfg_write(4'd15);
    for (int i = 0; i < LANES; i++)
      push_word(LANE_W'(i), 64'hAAAA_5555_0000_0010 - i, ~32'(i), 1'b0);
    settle();
    // shrink to two lanes, both holding heads: an ignored word lets a row out
    cfg_write(4'd2);
    push_word(3'd5, 64'h0, 32'd0, 1'b0);
    settle();

    run_phase(4'd1, 20, 0, 1'b0);
    run_phase(4'd3, 25, 0, 1'b0);
    send_idle = 71;
    recv_idle = 26;
    run_phase(4'd15, 25, 0, 1'b0);
    run_phase(4'd5, 20, 0, 1'b0);
    send_idle = 0;
    recv_idle = 0;
    run_phase(4'd8, 30, 0, 1'b1);

    // streams end one by one until no lane is left
    for (int k = 0; k < 80 && lane_ended != '1; k++) stream_word(15, useful);
    for (int k = 0; k < 4; k++) noise_word(1'b0);
    settle();

    $display("Covered %0d record words and %0d result words over lane settings",
             in_words, out_words);
    $display("8, 0, 15, 2, 1, 3, 15, 5 and 8, with backpressure, a long stall and lane ends");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: kway_sorted_count_merge.f
hw/rtl/kscm_pkg.sv
hw/rtl/kscm_if.sv
hw/rtl/kscm_cell.sv
hw/rtl/kway_sorted_count_merge.sv
tb/kscm_merge_checker.sv
tb/tb_top.sv
